// File: hw/rtl/csl_pkg.sv
package csl_pkg;

  // Field widths fixed by the item format.
  localparam int SITE_W    = 9;
  localparam int SPECIES_W = 3;
  localparam int DRAW_W    = 16;
  localparam int CHANCE_W  = 17;
  localparam int CMD_W     = 2;

  // Reproduction chance after reset: always.
  localparam logic [CHANCE_W-1:0] CHANCE_RESET = 17'h10000;

  // Command codes; the fourth code is ignored.
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [SITE_W-1:0]    site_x;
    logic [SITE_W-1:0]    site_y;
    logic                 axis;
    logic                 direction;
    logic [DRAW_W-1:0]    chance_draw;
    logic [SPECIES_W-1:0] write_species;
  } req_t;

  typedef struct packed {
    logic [SPECIES_W-1:0] read_species;
    logic [SPECIES_W-1:0] met_species;
    logic                 reproduced;
  } rsp_t;

  // Sequencer states: idle, compute on read data, second write back.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WB
  } state_t;

endpackage

// File: hw/rtl/csl_if.sv
// Command channel.
interface csl_req_if;
  import csl_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface csl_rsp_if;
  import csl_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel for the reproduction chance.
interface csl_cfg_if;
  import csl_pkg::*;
  logic                valid;
  logic                ready;
  logic [CHANCE_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/csl_lattice_mem.sv
module csl_lattice_mem #(
  parameter int DEPTH = 262144,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [csl_pkg::SPECIES_W-1:0]  wdata,
  input  logic                           re,
  input  logic [AW-1:0]                  raddr_a,
  input  logic [AW-1:0]                  raddr_b,
  output logic [csl_pkg::SPECIES_W-1:0]  rdata_a,
  output logic [csl_pkg::SPECIES_W-1:0]  rdata_b
);
  import csl_pkg::*;

  logic [SPECIES_W-1:0] cells [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  // Two registered read ports; a read at the written address returns old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= cells[raddr_a];
      rdata_b <= cells[raddr_b];
    end
  end

endmodule

// File: hw/rtl/cyclic_species_lattice_step_unit.sv
// Periodic SIDE x SIDE lattice of species labels held in one on-chip memory with a
// single write port and two registered read ports. A read or write command reads
// its cell into a read register, then loads its result into the output register.
// An update reads site and neighbor together, then writes the neighbor in compute
// and the site in write back, split by the one write port; the next command is
// accepted during write back. The lattice comes up undefined and uncleared; software
// must write every cell before any read or update, and the block does not enforce it.
// Commands whose site lies outside the lattice, and the unused command code,
// leave the lattice alone and return an all-zero result. The result sits in an
// output register, so the next command is still accepted and its cells read while
// a result waits; that command then holds in compute until the result is taken.
module cyclic_species_lattice_step_unit #(
  parameter int SIDE    = 512,
  parameter int SPECIES = 5
) (
  input  logic      clk,
  input  logic      rst,
  csl_req_if.sink   req,
  csl_rsp_if.source rsp,
  csl_cfg_if.sink   cfg
);
  import csl_pkg::*;

  localparam int DEPTH   = SIDE * SIDE;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(SIDE);
  localparam int RANGE_W = 11;
  localparam int PREY_W  = SPECIES_W + 1;

  // Prey of a label: (label + 1) mod SPECIES, by repeated subtraction.
  function automatic logic [SPECIES_W-1:0] prey_of(input logic [SPECIES_W-1:0] s);
    logic [PREY_W-1:0] v;
    v = {1'b0, s} + PREY_W'(1);
    for (int i = 0; i < 4; i++) begin
      if (v >= PREY_W'(SPECIES)) begin
        v = v - PREY_W'(SPECIES);
      end
    end
    return v[SPECIES_W-1:0];
  endfunction

  // Wrapped step of one coordinate.
  function automatic logic [CW-1:0] wrap_step(input logic [CW-1:0] v, input logic dir);
    logic [CW-1:0] r;
    if (dir) begin
      r = (v == CW'(SIDE - 1)) ? '0 : v + CW'(1);
    end else begin
      r = (v == '0) ? CW'(SIDE - 1) : v - CW'(1);
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [CHANCE_W-1:0]  chance;
  logic [CMD_W-1:0]     cmd_q;
  logic                 ok_q;
  logic [AW-1:0]        here_q;
  logic [AW-1:0]        there_q;
  logic [DRAW_W-1:0]    draw_q;
  logic [SPECIES_W-1:0] wspec_q;
  logic                 fwd_a;
  logic                 fwd_b;
  logic [SPECIES_W-1:0] fwd_data;
  logic [SPECIES_W-1:0] wb_data;
  logic                 out_valid;
  rsp_t                 out_data;

  logic                 accept;
  logic                 load;
  logic                 in_range;
  logic [CW-1:0]        x_c, y_c, nx_c, ny_c;
  logic [AW-1:0]        here_addr, there_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [SPECIES_W-1:0] mem_wdata;
  logic [SPECIES_W-1:0] rd_a, rd_b;
  logic [SPECIES_W-1:0] mover, met;
  logic                 is_update, is_write, is_read;
  logic                 rep;
  rsp_t                 result;

  // Configuration register; writes are always taken.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      chance <= CHANCE_RESET;
    end else if (cfg.valid) begin
      chance <= cfg.data;
    end
  end

  // Site and neighbor addresses of the incoming command.
  assign in_range = ({2'b00, req.data.site_x} < RANGE_W'(SIDE)) &&
                    ({2'b00, req.data.site_y} < RANGE_W'(SIDE));
  assign x_c  = CW'(req.data.site_x);
  assign y_c  = CW'(req.data.site_y);
  assign nx_c = req.data.axis ? x_c : wrap_step(x_c, req.data.direction);
  assign ny_c = req.data.axis ? wrap_step(y_c, req.data.direction) : y_c;
  assign here_addr  = AW'(x_c) * AW'(SIDE) + AW'(y_c);
  assign there_addr = AW'(nx_c) * AW'(SIDE) + AW'(ny_c);

  // Cell values with the pending site write back forwarded.
  assign mover = fwd_a ? fwd_data : rd_a;
  assign met   = fwd_b ? fwd_data : rd_b;

  assign is_update = ok_q && (cmd_q == CMD_UPDATE);
  assign is_write  = ok_q && (cmd_q == CMD_WRITE);
  assign is_read   = ok_q && (cmd_q == CMD_READ);
  assign rep = is_update && (met == prey_of(mover)) && ({1'b0, draw_q} < chance);

  // Result of the command in the compute cycle.
  always_comb begin
    result = '0;
    if (is_update) begin
      result.read_species = mover;
      result.met_species  = met;
      result.reproduced   = rep;
    end else if (is_read) begin
      result.read_species = mover;
    end
  end

  // Sequencer: next state, handshakes and write port.
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    load       = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = here_q;
    mem_wdata  = wspec_q;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (is_update) begin
          mem_we    = 1'b1;
          mem_waddr = there_q;
          mem_wdata = mover;
        end else if (is_write) begin
          mem_we = 1'b1;
        end
        if (!out_valid || rsp.ready) begin
          load       = 1'b1;
          state_next = is_update ? ST_WB : ST_IDLE;
        end
      end
      ST_WB: begin
        mem_we    = 1'b1;
        mem_wdata = wb_data;
        req.ready = 1'b1;
        state_next = req.valid ? ST_CALC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command capture, with a forwarding mark when a read hits the site being written.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= req.data.command;
      ok_q     <= in_range;
      here_q   <= here_addr;
      there_q  <= there_addr;
      draw_q   <= req.data.chance_draw;
      wspec_q  <= req.data.write_species;
      fwd_a    <= (state == ST_WB) && (here_addr == here_q);
      fwd_b    <= (state == ST_WB) && (there_addr == here_q);
      fwd_data <= wb_data;
    end
    if (state == ST_CALC) begin
      wb_data <= rep ? mover : met;
    end
  end

  csl_lattice_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (accept),
    .raddr_a (here_addr),
    .raddr_b (there_addr),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // An accepted beat is always worked on in the next cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> state == ST_CALC)
    else $error("accepted beat did not reach compute");

  // An update that finishes compute always writes its site back next.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) && load && is_update |=> (state == ST_WB) && mem_we)
    else $error("update skipped site write back");

  // The lattice is never written while the unit is idle.
  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !mem_we)
    else $error("lattice written while idle");

  // A new result only appears after a compute cycle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_CALC)
    else $error("result appeared without compute");

endmodule
